// File: rtl/fenwick_2d_range_sum_defines.svh
// Assertion macros shared by the range-sum block.
// Both expect signals named clock and reset in the module that uses them.
`ifndef FENWICK_2D_RANGE_SUM_DEFINES_SVH
`define FENWICK_2D_RANGE_SUM_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define FW2_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fw2 assertion failed");

// Next-cycle implication
`define FW2_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fw2 assertion failed");

`else

`define FW2_ASSERT_IMP(label, ante, cons)
`define FW2_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: rtl/fw2_pkg.sv
package fw2_pkg;

   // Matrix extent held by the tree store
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int MAX_DIM  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ADDR_W = ROW_W + COL_W;
   // 1-based tree index; an upward step may reach twice the extent
   localparam int IDX_W  = $clog2(2 * MAX_DIM + 1);

   localparam int DATA_W = 32;
   localparam int SIZE_W = 7;

   // Commands
   localparam logic CMD_SET   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_WALK,
      ST_DRAIN,
      ST_DELTA,
      ST_UPDATE,
      ST_UDRAIN,
      ST_FINISH
   } fw2_state_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
   } fw2_mem_req_type;

   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] sum;
      logic              status;
   } fw2_result_type;

   // Lowest set bit of a tree index
   function automatic logic [IDX_W-1:0] low_bit(input logic [IDX_W-1:0] n);
      logic [IDX_W-1:0] neg;
      neg = ~n + 1'b1;
      return n & neg;
   endfunction

endpackage

// File: rtl/fenwick_2d_range_sum.sv
// Rectangle sums over a matrix of up to 64 x 64 signed 32-bit cells, kept as a
// two-dimensional binary indexed tree in one single-port-read, single-port-write RAM.
// Request beats (req_*): cmd 0 sets the cell at row_first/col_first to value and
// returns its old value; cmd 1 returns the sum of the rectangle row_first..row_last,
// col_first..col_last. Sums wrap modulo 2^32. A cell or corner outside the size
// set in csr registers 0 (rows) and 1 (columns), or a reversed rectangle, returns
// status 1 and sum 0 with the store untouched.
// One request is processed at a time; req_stall stays high until it is done.
// The RAM read port reads one tree node per cycle: the four prefix walks of a query
// read at most 121 nodes; a set reads its cell the same way and then rewrites at
// most 49 nodes; a rejected request goes from idle straight to the result.
// The result sits in an output register; the next request is taken while it
// waits under rsp_stall, but that request cannot finish until the register frees.
// After reset the RAM's 4096 words are cleared one word a cycle with req_stall
// high; csr writes are taken throughout. Sizes reset to 64 x 64.
`include "fenwick_2d_range_sum_defines.svh"

module fenwick_2d_range_sum (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [fw2_pkg::ROW_W-1:0]     req_row_first,
   input  logic [fw2_pkg::COL_W-1:0]     req_col_first,
   input  logic [fw2_pkg::ROW_W-1:0]     req_row_last,
   input  logic [fw2_pkg::COL_W-1:0]     req_col_last,
   input  logic signed [fw2_pkg::DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [fw2_pkg::DATA_W-1:0] rsp_sum,
   output logic                          rsp_status,
   input  logic                          csr_write_enable,
   input  logic [fw2_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fw2_pkg::SIZE_W-1:0]    csr_write_data
);
   import fw2_pkg::*;

   logic [SIZE_W-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [SIZE_W-1:0] rows_eff, cols_eff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic              rsp_status_ff, rsp_status_in;

   logic              ctrl_idle;
   logic              out_free;
   fw2_mem_req_type   mem_req;
   logic [DATA_W-1:0] rd_data;
   fw2_result_type    res;

   fw2_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   fw2_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_cmd       (req_cmd),
      .req_row_first (req_row_first),
      .req_col_first (req_col_first),
      .req_row_last  (req_row_last),
      .req_col_last  (req_col_last),
      .req_value     (req_value),
      .rows_eff      (rows_eff),
      .cols_eff      (cols_eff),
      .idle          (ctrl_idle),
      .mem_req       (mem_req),
      .rd_data       (rd_data),
      .out_free      (out_free),
      .result        (res)
   );

   // Size registers
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ROWS: rows_in = csr_write_data;
            CSR_COLS: cols_in = csr_write_data;
            default: begin
               rows_in = rows_ff;
               cols_in = cols_ff;
            end
         endcase
      end
   end

   // Clamp sizes to the store extent
   assign rows_eff = (rows_ff > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_ff;
   assign cols_eff = (cols_ff > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : cols_ff;

   // Output register: load a finished result, drop it once taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      if (res.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_sum_in    = res.sum;
         rsp_status_in = res.status;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= SIZE_W'(MAX_ROWS);
         cols_ff      <= SIZE_W'(MAX_COLS);
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall  = !ctrl_idle;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sum    = rsp_sum_ff;
   assign rsp_status = rsp_status_ff;

   // A new result never overwrites one still held under stall
   `FW2_ASSERT_IMP(a_no_overwrite, res.valid, !rsp_valid_ff || !rsp_stall)

endmodule

// File: rtl/fw2_store.sv
module fw2_store (
   input  logic                     clock,
   input  fw2_pkg::fw2_mem_req_type mem_req,
   output logic [fw2_pkg::DATA_W-1:0] rd_data
);
   import fw2_pkg::*;

   logic [DATA_W-1:0] mem_ff [0:(1 << ADDR_W)-1];
   logic [DATA_W-1:0] rd_data_ff;

   // Write one word, read one word with registered data
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/fw2_alu.sv
module fw2_alu (
   input  logic [fw2_pkg::DATA_W-1:0] op_a,
   input  logic [fw2_pkg::DATA_W-1:0] op_b,
   input  logic                       op_sub,
   output logic [fw2_pkg::DATA_W-1:0] result
);
   import fw2_pkg::*;

   logic [DATA_W-1:0] b_eff;

   // Add or subtract, wrapping at the word width
   assign b_eff  = op_sub ? ~op_b : op_b;
   assign result = op_a + b_eff + {{(DATA_W-1){1'b0}}, op_sub};

endmodule

// File: rtl/fw2_ctrl.sv
`include "fenwick_2d_range_sum_defines.svh"

module fw2_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_cmd,
   input  logic [fw2_pkg::ROW_W-1:0]  req_row_first,
   input  logic [fw2_pkg::COL_W-1:0]  req_col_first,
   input  logic [fw2_pkg::ROW_W-1:0]  req_row_last,
   input  logic [fw2_pkg::COL_W-1:0]  req_col_last,
   input  logic [fw2_pkg::DATA_W-1:0] req_value,
   input  logic [fw2_pkg::SIZE_W-1:0] rows_eff,
   input  logic [fw2_pkg::SIZE_W-1:0] cols_eff,
   output logic                       idle,
   output fw2_pkg::fw2_mem_req_type   mem_req,
   input  logic [fw2_pkg::DATA_W-1:0] rd_data,
   input  logic                       out_free,
   output fw2_pkg::fw2_result_type    result
);
   import fw2_pkg::*;

   fw2_state_type     state_ff, state_in;
   logic              cmd_ff, cmd_in;
   logic [IDX_W-1:0]  r1_ff, r1_in, c1_ff, c1_in;
   logic [IDX_W-1:0]  r2p_ff, r2p_in, c2p_ff, c2p_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [1:0]        p_ff, p_in;
   logic [IDX_W-1:0]  i_ff, i_in, j_ff, j_in, jst_ff, jst_in;
   logic [DATA_W-1:0] acc_ff, acc_in, delta_ff, delta_in;
   logic              dv_ff, dv_in, dsgn_ff, dsgn_in;
   logic [ADDR_W-1:0] daddr_ff, daddr_in;
   logic              err_ff, err_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;

   logic              accept, ok;
   logic [IDX_W-1:0]  pr, pc;
   logic [IDX_W-1:0]  j_down, i_down, j_up, i_up;
   logic [ROW_W-1:0]  row_addr;
   logic [COL_W-1:0]  col_addr;
   logic              upd_mode;
   logic [DATA_W-1:0] alu_a, alu_b, alu_y;
   logic              alu_sub;

   fw2_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .op_sub (alu_sub),
      .result (alu_y)
   );

   assign idle   = (state_ff == ST_IDLE);
   assign accept = req_valid && idle;

   // Range check of the incoming command
   always_comb begin
      if (req_cmd == CMD_SET) begin
         ok = (SIZE_W'(req_row_first) < rows_eff) && (SIZE_W'(req_col_first) < cols_eff);
      end else begin
         ok = (req_row_first <= req_row_last) && (req_col_first <= req_col_last) &&
              (SIZE_W'(req_row_last) < rows_eff) && (SIZE_W'(req_col_last) < cols_eff);
      end
   end

   // Corner of the current prefix sum
   always_comb begin
      case (p_ff)
         2'd0: begin pr = r2p_ff; pc = c2p_ff; end
         2'd1: begin pr = r1_ff;  pc = c1_ff;  end
         2'd2: begin pr = r2p_ff; pc = c1_ff;  end
         default: begin pr = r1_ff; pc = c2p_ff; end
      endcase
   end

   // Tree index steps
   assign j_down   = j_ff - low_bit(j_ff);
   assign i_down   = i_ff - low_bit(i_ff);
   assign j_up     = j_ff + low_bit(j_ff);
   assign i_up     = i_ff + low_bit(i_ff);
   assign row_addr = ROW_W'(i_ff - 1'b1);
   assign col_addr = COL_W'(j_ff - 1'b1);
   assign upd_mode = (state_ff == ST_UPDATE) || (state_ff == ST_UDRAIN);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      r1_in    = r1_ff;
      c1_in    = c1_ff;
      r2p_in   = r2p_ff;
      c2p_in   = c2p_ff;
      val_in   = val_ff;
      p_in     = p_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      jst_in   = jst_ff;
      delta_in = delta_ff;
      err_in   = err_ff;
      clr_in   = clr_ff;

      mem_req         = '0;
      result          = '0;
      result.sum      = acc_ff;
      result.status   = err_ff;

      // Shared adder: accumulate by default
      alu_a   = acc_ff;
      alu_b   = rd_data;
      alu_sub = dsgn_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_ff;
            clr_in          = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_cmd;
               r1_in  = IDX_W'(req_row_first);
               c1_in  = IDX_W'(req_col_first);
               val_in = req_value;
               p_in   = 2'd0;
               err_in = ok ? STATUS_OK : STATUS_ERR;
               if (req_cmd == CMD_SET) begin
                  r2p_in = IDX_W'(req_row_first) + 1'b1;
                  c2p_in = IDX_W'(req_col_first) + 1'b1;
               end else begin
                  r2p_in = IDX_W'(req_row_last) + 1'b1;
                  c2p_in = IDX_W'(req_col_last) + 1'b1;
               end
               state_in = ok ? ST_LOAD : ST_FINISH;
            end
         end
         ST_LOAD: begin
            if (pr == '0 || pc == '0) begin
               // Empty prefix: skip it
               if (p_ff == 2'd3) begin
                  state_in = ST_DRAIN;
               end else begin
                  p_in = p_ff + 1'b1;
               end
            end else begin
               i_in     = pr;
               j_in     = pc;
               jst_in   = pc;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = {row_addr, col_addr};
            if (j_down != '0) begin
               j_in = j_down;
            end else if (i_down != '0) begin
               i_in = i_down;
               j_in = jst_ff;
            end else if (p_ff == 2'd3) begin
               state_in = ST_DRAIN;
            end else begin
               p_in     = p_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_DRAIN: begin
            state_in = (cmd_ff == CMD_SET) ? ST_DELTA : ST_FINISH;
         end
         ST_DELTA: begin
            alu_a    = val_ff;
            alu_b    = acc_ff;
            alu_sub  = 1'b1;
            delta_in = alu_y;
            i_in     = r1_ff + 1'b1;
            j_in     = c1_ff + 1'b1;
            jst_in   = c1_ff + 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            alu_a           = rd_data;
            alu_b           = delta_ff;
            alu_sub         = 1'b0;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = {row_addr, col_addr};
            if (j_up <= IDX_W'(MAX_COLS)) begin
               j_in = j_up;
            end else if (i_up <= IDX_W'(MAX_ROWS)) begin
               i_in = i_up;
               j_in = jst_ff;
            end else begin
               state_in = ST_UDRAIN;
            end
         end
         ST_UDRAIN: begin
            alu_a    = rd_data;
            alu_b    = delta_ff;
            alu_sub  = 1'b0;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            result.valid = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Write back the node read in the previous cycle
      if (upd_mode && dv_ff) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = daddr_ff;
         mem_req.wr_data = alu_y;
      end
   end

   // Accumulate returning reads during the prefix walk
   always_comb begin
      if (accept) begin
         acc_in = '0;
      end else if (dv_ff && !upd_mode) begin
         acc_in = alu_y;
      end else begin
         acc_in = acc_ff;
      end
   end

   assign dv_in    = mem_req.rd_en;
   assign dsgn_in  = p_ff[1];
   assign daddr_in = mem_req.rd_addr;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         dv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         dv_ff    <= dv_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      r1_ff    <= r1_in;
      c1_ff    <= c1_in;
      r2p_ff   <= r2p_in;
      c2p_ff   <= c2p_in;
      val_ff   <= val_in;
      p_ff     <= p_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      jst_ff   <= jst_in;
      acc_ff   <= acc_in;
      delta_ff <= delta_in;
      dsgn_ff  <= dsgn_in;
      daddr_ff <= daddr_in;
      err_ff   <= err_in;
   end

   // A write-back never targets the node being read in the same cycle
   `FW2_ASSERT_IMP(a_rmw_no_clash, mem_req.wr_en && mem_req.rd_en,
                   mem_req.wr_addr != mem_req.rd_addr)
   // The store is written only while clearing or updating
   `FW2_ASSERT_IMP(a_write_phase, mem_req.wr_en,
                   state_ff == ST_CLEAR || state_ff == ST_UPDATE || state_ff == ST_UDRAIN)
   // A rejected command goes straight to the result
   `FW2_ASSERT_NXT(a_err_finish, accept && !ok, state_ff == ST_FINISH && acc_ff == '0)

endmodule

// File: tb/tb_fenwick_2d_range_sum.sv
module tb_fenwick_2d_range_sum;
   import fw2_pkg::*;

   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int LONG_HOLD     = 1500;
   localparam int TAIL_CYCLES   = 300;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 161;

   typedef struct {
      logic              cmd;
      logic [ROW_W-1:0]  row_first;
      logic [COL_W-1:0]  col_first;
      logic [ROW_W-1:0]  row_last;
      logic [COL_W-1:0]  col_last;
      logic [DATA_W-1:0] value;
   } range_cmd_type;

   typedef struct {
      logic [DATA_W-1:0] sum;
      logic              status;
   } range_result_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   // DUT connections
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_cmd = CMD_SET;
   logic [ROW_W-1:0]         req_row_first = '0;
   logic [COL_W-1:0]         req_col_first = '0;
   logic [ROW_W-1:0]         req_row_last = '0;
   logic [COL_W-1:0]         req_col_last = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_sum;
   logic                     rsp_status;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_ROWS;
   logic [SIZE_W-1:0]        csr_write_data = '0;

   // Shadow matrix and size registers
   logic [DATA_W-1:0] cell_value [MAX_ROWS][MAX_COLS];
   logic [SIZE_W-1:0] rows_cfg = 7'd64;
   logic [SIZE_W-1:0] cols_cfg = 7'd64;

   range_cmd_type    pending_commands [$];
   range_result_type expected_results [$];
   range_cmd_type    on_bus;
   range_result_type oldest_result;

   int burst_left = 0;
   int gap_left = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int mode_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int cycle_count = 0;
   int error_count = 0;
   int set_ok_count = 0;
   int query_ok_count = 0;
   int reject_count = 0;
   int phase_count = 0;

   fenwick_2d_range_sum u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_row_first    (req_row_first),
      .req_col_first    (req_col_first),
      .req_row_last     (req_row_last),
      .req_col_last     (req_col_last),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sum          (rsp_sum),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned rows_active();
      return (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
   endfunction

   function automatic int unsigned cols_active();
      return (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
   endfunction

   // Apply one command to the shadow matrix and return the result it gives
   function automatic range_result_type apply_range_command(input range_cmd_type rc);
      range_result_type res;
      int unsigned      nr;
      int unsigned      nc;
      res.sum    = '0;
      res.status = STATUS_ERR;
      nr = rows_active();
      nc = cols_active();
      if (rc.cmd == CMD_SET) begin
         if (rc.row_first < nr && rc.col_first < nc) begin
            res.sum    = cell_value[rc.row_first][rc.col_first];
            res.status = STATUS_OK;
            cell_value[rc.row_first][rc.col_first] = rc.value;
            set_ok_count++;
         end
      end else if (rc.row_first <= rc.row_last && rc.col_first <= rc.col_last &&
                   rc.row_last < nr && rc.col_last < nc) begin
         for (int r = rc.row_first; r <= rc.row_last; r++)
            for (int c = rc.col_first; c <= rc.col_last; c++)
               res.sum += cell_value[r][c];
         res.status = STATUS_OK;
         query_ok_count++;
      end
      if (res.status == STATUS_ERR)
         reject_count++;
      return res;
   endfunction

   function automatic logic [DATA_W-1:0] random_value();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 200) - 100;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'hFFFF_FFFF;
               default: return '0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Mostly well-formed sets and queries inside the active size, some noise
   function automatic range_cmd_type random_cmd();
      range_cmd_type rc;
      int unsigned   nr;
      int unsigned   nc;
      int unsigned   roll;
      nr = rows_active();
      nc = cols_active();
      roll = $urandom_range(0, 19);
      rc.cmd       = 1'($urandom_range(0, 1));
      rc.row_first = ROW_W'($urandom);
      rc.col_first = COL_W'($urandom);
      rc.row_last  = ROW_W'($urandom);
      rc.col_last  = COL_W'($urandom);
      rc.value     = random_value();
      if (nr == 0 || nc == 0 || roll >= 18)
         return rc;
      rc.row_first = ROW_W'($urandom_range(0, nr - 1));
      rc.col_first = COL_W'($urandom_range(0, nc - 1));
      if (roll < 9) begin
         rc.cmd = CMD_SET;
      end else begin
         rc.cmd      = CMD_QUERY;
         rc.row_last = ROW_W'($urandom_range(rc.row_first, nr - 1));
         rc.col_last = COL_W'($urandom_range(rc.col_first, nc - 1));
      end
      return rc;
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0: return 7'd1;
         1: return 7'd64;
         2: return SIZE_W'($urandom_range(65, 127));
         default: return SIZE_W'($urandom_range(1, 64));
      endcase
   endfunction

   task automatic queue_cmd(input logic cmd, input int r1, input int c1,
                            input int r2, input int c2, input logic [DATA_W-1:0] v);
      range_cmd_type rc;
      rc.cmd       = cmd;
      rc.row_first = ROW_W'(r1);
      rc.col_first = COL_W'(c1);
      rc.row_last  = ROW_W'(r2);
      rc.col_last  = COL_W'(c2);
      rc.value     = v;
      pending_commands.push_back(rc);
   endtask

   task automatic write_size(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] size);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= size;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_ROWS)
         rows_cfg = size;
      else
         cols_cfg = size;
   endtask

   task automatic set_sizes(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols);
      write_size(CSR_ROWS, rows);
      write_size(CSR_COLS, cols);
      phase_count++;
   endtask

   task automatic wait_drained();
      while (pending_commands.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // Sender: bursts of beats with random gaps, payload held while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            expected_results.push_back(apply_range_command(on_bus));
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_commands.size() != 0) begin
            on_bus = pending_commands.pop_front();
            req_cmd       <= on_bus.cmd;
            req_row_first <= on_bus.row_first;
            req_col_first <= on_bus.col_first;
            req_row_last  <= on_bus.row_last;
            req_col_last  <= on_bus.col_last;
            req_value     <= on_bus.value;
            req_valid     <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 8);
               gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 250)
                                                      : $urandom_range(0, 12);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall pattern of its own, plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(50, 400);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               STALL_NONE:   rsp_stall <= 1'b0;
               STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
               STALL_TOGGLE: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // Check each result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with none expected, sum %h status %b",
                     $time, rsp_sum, rsp_status);
            error_count++;
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_sum !== oldest_result.sum) begin
               $display("%0t: sum mismatch, expected %h, actual %h",
                        $time, oldest_result.sum, rsp_sum);
               error_count++;
            end
            if (rsp_status !== oldest_result.status) begin
               $display("%0t: status mismatch, expected %b, actual %b",
                        $time, oldest_result.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
         $display("[fenwick_2d_range_sum] ERROR");
         $finish;
      end
   end

   initial begin
      for (int r = 0; r < MAX_ROWS; r++)
         for (int c = 0; c < MAX_COLS; c++)
            cell_value[r][c] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Full size: corner cells, extreme values, wrapping sums, reversed corners
      set_sizes(7'd64, 7'd64);
      queue_cmd(CMD_SET, 0, 0, 0, 0, 32'h7FFF_FFFF);
      queue_cmd(CMD_SET, 63, 63, 0, 0, 32'h8000_0000);
      queue_cmd(CMD_SET, 0, 63, 63, 63, 32'hFFFF_FFFF);
      queue_cmd(CMD_SET, 63, 0, 17, 42, 32'h0000_0001);
      queue_cmd(CMD_SET, 0, 0, 0, 0, 32'h0000_0005);
      queue_cmd(CMD_QUERY, 0, 0, 63, 63, 32'hFFFF_FFFF);
      queue_cmd(CMD_QUERY, 63, 63, 63, 63, 32'h0);
      queue_cmd(CMD_QUERY, 1, 1, 62, 62, 32'h0);
      queue_cmd(CMD_QUERY, 5, 0, 4, 63, 32'h0);
      queue_cmd(CMD_QUERY, 0, 9, 63, 8, 32'h0);
      wait_drained();

      // Shrink: cells and corners past the size are rejected
      set_sizes(7'd10, 7'd20);
      queue_cmd(CMD_SET, 9, 19, 0, 0, 32'd123);
      queue_cmd(CMD_SET, 10, 0, 0, 0, 32'd77);
      queue_cmd(CMD_SET, 0, 20, 0, 0, 32'd77);
      queue_cmd(CMD_QUERY, 0, 0, 9, 19, 32'h0);
      queue_cmd(CMD_QUERY, 0, 0, 10, 19, 32'h0);
      queue_cmd(CMD_QUERY, 0, 0, 63, 63, 32'h0);
      wait_drained();

      // Zero rows: everything rejected
      set_sizes(7'd0, 7'd1);
      queue_cmd(CMD_SET, 0, 0, 0, 0, 32'd9);
      queue_cmd(CMD_QUERY, 0, 0, 0, 0, 32'h0);
      wait_drained();

      // Single cell
      set_sizes(7'd1, 7'd1);
      queue_cmd(CMD_SET, 0, 0, 0, 0, -32'sd7);
      queue_cmd(CMD_QUERY, 0, 0, 0, 0, 32'h0);
      queue_cmd(CMD_QUERY, 0, 0, 0, 1, 32'h0);
      wait_drained();

      // Oversized registers act as the maximum; earlier cells show again
      set_sizes(7'd127, 7'd65);
      queue_cmd(CMD_QUERY, 0, 0, 63, 63, 32'h0);
      queue_cmd(CMD_QUERY, 9, 19, 9, 19, 32'h0);
      queue_cmd(CMD_SET, 63, 63, 0, 0, $urandom);
      wait_drained();

      // Random phases, each under its own size setting
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0)
            set_sizes(7'd64, 7'd64);
         else
            set_sizes(pick_size(), pick_size());
         if (p == 5) begin
            // hold the sender until everything has come back, then resume
            repeat (PHASE_ITEMS / 2) pending_commands.push_back(random_cmd());
            wait_drained();
            repeat (PHASE_ITEMS - PHASE_ITEMS / 2) pending_commands.push_back(random_cmd());
         end else begin
            repeat (PHASE_ITEMS) pending_commands.push_back(random_cmd());
         end
         if (p == 3 || p == 8)
            hold_requests++;
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_results.size());
         error_count++;
      end
      $display("Covered %0d cell writes, %0d rectangle queries and %0d rejected commands",
               set_ok_count, query_ok_count, reject_count);
      $display("across %0d size settings, with %0d mismatches", phase_count, error_count);
      if (error_count == 0)
         $display("[fenwick_2d_range_sum] OK");
      else
         $display("[fenwick_2d_range_sum] ERROR");
      $finish;
   end

endmodule
